@@ sv/sscf_pkg.sv @@
package sscf_pkg;

    localparam logic [1:0] MODE_EVAL  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_SLIDE = 2'd2;

    localparam int W_IN_DATA  = 264;
    localparam int W_OUT_DATA = 160;

    // per-contact parameter record held in the parameter memory
    typedef struct packed {
        logic [30:0] kn;
        logic [31:0] xn0;
        logic [15:0] mu1;
        logic [15:0] mu2;
        logic [30:0] kt1;
        logic [30:0] kt2;
    } t_params;

    // divider request and response between the top level and the divide unit
    typedef struct packed {
        logic        start;
        logic [50:0] num;
        logic [30:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [50:0] quo;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

@@ sv/sscf_div.sv @@
// restoring divider, one quotient bit per cycle
module sscf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sscf_pkg::t_div_req i_req,
    output sscf_pkg::t_div_rsp o_rsp
);
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [50:0] r_num;
    logic [31:0] r_rem;
    logic [30:0] r_den;
    logic [50:0] r_quo;
    logic [31:0] n_rem_sh;

    assign n_rem_sh = {r_rem[30:0], r_num[50]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 6'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd51;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[49:0], 1'b0};
                if (n_rem_sh >= {1'b0, r_den}) begin
                    r_rem <= n_rem_sh - {1'b0, r_den};
                    r_quo <= {r_quo[49:0], 1'b1};
                end else begin
                    r_rem <= n_rem_sh;
                    r_quo <= {r_quo[49:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

@@ sv/stick_slip_contact_force_core.sv @@
// channel | dir | tdata fields (low bit up)                              | tuser
// s_axis  | in  | contact_index, disp_t1, disp_t2, disp_n, load_normal_  | mode
//         |     | stiffness, load_normal_offset, load_friction_t1/t2,    |
//         |     | load_stiffness_t1/t2                                   |
// m_axis  | out | force_t1, force_t2, force_n, slider_t1, slider_t2      | sliding_t1, sliding_t2
// one item at a time: load, slider set, unused mode or ignored index pass the read and output
// states; an evaluation also passes the normal-force and per-direction states, and a sliding
// direction waits on the 51-step divider shared by the two directions.
// parameters live in one memory, sliders in a second; both are read into registers in the idle state.
// after reset a clearing pass zeroes all 2*NUM_CONTACTS slider entries.
// a result waits in the output register while the next item is taken and worked on
module stick_slip_contact_force_core #(
    parameter int NUM_CONTACTS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // index, t1, t2, n, kn, xn0, mu1, mu2, kt1, kt2
    input  logic [sscf_pkg::W_IN_DATA-1:0]   s_axis_tdata,
    input  logic [1:0]                       s_axis_tuser,  // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // force_t1, force_t2, force_n, slider_t1, slider_t2
    output logic [sscf_pkg::W_OUT_DATA-1:0]  m_axis_tdata,
    output logic [1:0]                       m_axis_tuser   // sliding_t1, sliding_t2
);
    localparam int AW  = (NUM_CONTACTS > 1) ? $clog2(NUM_CONTACTS) : 1;
    localparam int SW  = AW + 1;
    localparam int NS  = 2 * NUM_CONTACTS;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_FN   = 4'd3;
    localparam logic [3:0] ST_D1   = 4'd4;
    localparam logic [3:0] ST_T    = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_WB   = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    sscf_pkg::t_params r_pmem [NUM_CONTACTS];
    logic [31:0]       r_smem [NS];

    logic [3:0]  r_state;
    logic [SW:0] r_clr;
    logic [1:0]  r_mode;
    logic [5:0]  r_idx;
    logic        r_inrange;
    logic signed [31:0] r_x1, r_x2, r_xn;
    sscf_pkg::t_params r_prd;
    sscf_pkg::t_params r_lprm;
    logic [31:0] r_w1rd, r_w2rd;
    logic        r_dir;
    logic [30:0] r_fn;
    logic [32:0] r_mag;
    logic        r_neg;
    logic [34:0] r_lim;
    logic signed [31:0] r_f1, r_f2, r_w1, r_w2;
    logic        r_s1, r_s2;
    logic        r_pos;
    logic        r_ovld;
    logic [sscf_pkg::W_OUT_DATA-1:0] r_odata;
    logic [1:0]  r_ouser;
    logic        r_div_go;

    sscf_pkg::t_div_req div_req;
    sscf_pkg::t_div_rsp div_rsp;

    sscf_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic [AW-1:0] idx_a;
    assign idx_a = AW'(r_idx);

    logic [5:0] in_idx;
    assign in_idx = s_axis_tdata[5:0];
    logic [AW-1:0] in_a;
    assign in_a = AW'(in_idx);
    assign s_axis_tready = (r_state == ST_IDLE);

    // current direction values
    logic signed [31:0] cur_x, cur_w;
    logic [30:0] cur_kt;
    logic [15:0] cur_mu;
    assign cur_x  = r_dir ? r_x2 : r_x1;
    assign cur_w  = r_dir ? r_w2rd : r_w1rd;
    assign cur_kt = r_dir ? r_prd.kt2 : r_prd.kt1;
    assign cur_mu = r_dir ? r_prd.mu2 : r_prd.mu1;

    logic signed [32:0] d_val, u_val;
    assign d_val = 33'(cur_x) - 33'(cur_w);
    assign u_val = 33'(r_xn) - 33'($signed(r_prd.xn0));
    logic [64:0] kn_prod;
    assign kn_prod = {32'd0, u_val} * {34'd0, r_prd.kn};
    logic [63:0] t_prod;
    assign t_prod = {31'd0, r_mag} * {33'd0, cur_kt};
    logic [46:0] l_prod;
    assign l_prod = {16'd0, r_fn} * {31'd0, cur_mu};

    logic signed [35:0] sat_in_w;
    logic signed [31:0] slide_force;
    assign slide_force = sscf_pkg::sat32(r_pos ? $signed({1'b0, r_lim})
                                               : -$signed({1'b0, r_lim}));
    // quotients past 2^34 push the slider into saturation either way
    logic signed [35:0] q_s;
    assign q_s = (cur_kt == '0) ? 36'sd0
               : (div_rsp.quo[50:34] != '0) ? 36'sh4_0000_0000
               : $signed({2'b00, div_rsp.quo[33:0]});

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLR) begin
            r_smem[r_clr[SW-1:0]] <= '0;
        end else if (r_state == ST_RD && r_inrange && r_mode == sscf_pkg::MODE_SLIDE) begin
            r_smem[{idx_a, 1'b0}] <= r_x1;
            r_smem[{idx_a, 1'b1}] <= r_x2;
        end else if (r_state == ST_WB) begin
            r_smem[{idx_a, 1'b0}] <= r_w1;
            r_smem[{idx_a, 1'b1}] <= r_w2;
        end
        if (r_state == ST_IDLE) begin
            r_w1rd <= r_smem[{in_a, 1'b0}];
            r_w2rd <= r_smem[{in_a, 1'b1}];
            r_prd  <= r_pmem[in_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_ovld   <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            if (r_ovld && m_axis_tready) r_ovld <= 1'b0;
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + (SW+1)'(1);
                    if (r_clr == (SW+1)'(NS - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_mode    <= s_axis_tuser;
                        r_idx     <= in_idx;
                        r_inrange <= 32'(in_idx) < NUM_CONTACTS;
                        r_x1      <= s_axis_tdata[37:6];
                        r_x2      <= s_axis_tdata[69:38];
                        r_xn      <= s_axis_tdata[101:70];
                        r_state   <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_f1 <= '0; r_f2 <= '0; r_fn <= '0; r_s1 <= 1'b0; r_s2 <= 1'b0;
                    r_dir <= 1'b0;
                    r_w1 <= (r_mode == sscf_pkg::MODE_SLIDE) ? r_x1 : r_w1rd;
                    r_w2 <= (r_mode == sscf_pkg::MODE_SLIDE) ? r_x2 : r_w2rd;
                    if (r_inrange && r_mode == sscf_pkg::MODE_EVAL) begin
                        r_state <= ST_FN;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_FN: begin
                    if (!u_val[32] && u_val != '0) begin
                        r_fn <= (kn_prod[64:16] > 49'h7fffffff) ? 31'h7fffffff
                                                                 : kn_prod[46:16];
                    end
                    r_state <= ST_D1;
                end
                ST_D1: begin
                    if (r_fn == '0) begin
                        if (r_dir) begin
                            r_w2 <= cur_x; r_s2 <= 1'b1; r_state <= ST_WB;
                        end else begin
                            r_w1 <= cur_x; r_s1 <= 1'b1; r_dir <= 1'b1;
                        end
                    end else begin
                        r_neg   <= d_val[32];
                        r_mag   <= d_val[32] ? 33'(-d_val) : 33'(d_val);
                        r_state <= ST_T;
                    end
                end
                ST_T: begin
                    r_lim  <= l_prod[46:12];
                    r_pos  <= !r_neg && (t_prod[63:16] != '0);
                    if ({13'd0, l_prod[46:12]} > t_prod[63:16]) begin
                        if (r_dir) begin
                            r_f2 <= sscf_pkg::sat32(r_neg ? -$signed({1'b0, t_prod[50:16]})
                                                        : $signed({1'b0, t_prod[50:16]}));
                            r_state <= ST_WB;
                        end else begin
                            r_f1 <= sscf_pkg::sat32(r_neg ? -$signed({1'b0, t_prod[50:16]})
                                                        : $signed({1'b0, t_prod[50:16]}));
                            r_dir <= 1'b1;
                            r_state <= ST_D1;
                        end
                    end else begin
                        r_div_go <= 1'b1;
                        r_state  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_div_go <= 1'b0;
                    if (div_rsp.done) begin
                        if (r_dir) begin
                            r_f2 <= slide_force; r_s2 <= 1'b1;
                            r_w2 <= sscf_pkg::sat32(sat_in_w);
                            r_state <= ST_WB;
                        end else begin
                            r_f1 <= slide_force; r_s1 <= 1'b1;
                            r_w1 <= sscf_pkg::sat32(sat_in_w);
                            r_dir <= 1'b1;
                            r_state <= ST_D1;
                        end
                    end
                end
                ST_WB: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovld) begin
                        r_ovld <= 1'b1;
                        if (r_inrange) begin
                            r_odata <= {1'b0, r_w2, r_w1, r_fn, r_f2, r_f1};
                            r_ouser <= {r_s2, r_s1};
                        end else begin
                            r_odata <= '0;
                            r_ouser <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign sat_in_w = r_pos ? (36'(cur_x) - q_s) : (36'(cur_x) + q_s);

    // load records captured at the transfer then written in the read state
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid && s_axis_tready
            && s_axis_tuser == sscf_pkg::MODE_LOAD) begin
            r_lprm.kn  <= s_axis_tdata[132:102];
            r_lprm.xn0 <= s_axis_tdata[164:133];
            r_lprm.mu1 <= s_axis_tdata[180:165];
            r_lprm.mu2 <= s_axis_tdata[196:181];
            r_lprm.kt1 <= s_axis_tdata[227:197];
            r_lprm.kt2 <= s_axis_tdata[258:228];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD && r_inrange && r_mode == sscf_pkg::MODE_LOAD) begin
            r_pmem[idx_a] <= r_lprm;
        end
    end

    assign div_req.start = r_div_go;
    assign div_req.num   = {r_lim, 16'd0};
    assign div_req.den   = cur_kt;

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
endmodule
